@@ sv/aabb_pkg.sv @@
// ----------------------------------------------------------------------------
// AABB collision resolver package
// Shared item types, memory word layouts, sequencer states, codes and the
// signed 32-bit clamp used throughout the datapath.
// ----------------------------------------------------------------------------
package aabb_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int MUL_W       = 34;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int DIVIDEND_W  = 65;
    localparam int DIVISOR_W   = 33;

    localparam logic [2:0] KIND_WR_AXIS = 3'd0;
    localparam logic [2:0] KIND_WR_MASS = 3'd1;
    localparam logic [2:0] KIND_START   = 3'd2;
    localparam logic [2:0] KIND_COLLIDE = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;
    localparam logic [2:0] KIND_RD_AXIS = 3'd5;

    localparam logic [1:0] AXIS_X       = 2'd0;
    localparam logic [1:0] AXIS_Y       = 2'd1;
    localparam logic [1:0] AXIS_Z       = 2'd2;
    localparam logic [1:0] AXIS_NONE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 2'd1;

    localparam logic [15:0]        STEP_TIME_RST = 16'd1092;
    localparam logic signed [31:0] GRAVITY_RST   = 32'sd6426886;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         body;
        logic [3:0]         other_body;
        logic [1:0]         axis;
        logic signed [31:0] lo_coord;
        logic signed [31:0] hi_coord;
        logic signed [31:0] velocity;
        logic [31:0]        mass;
        logic               is_static;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_lo;
        logic signed [31:0] read_hi;
        logic signed [31:0] read_velocity;
        logic               collided;
        logic [1:0]         chosen_axis;
        logic               bounced;
        logic [3:0]         separation_steps;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] vel;
    } t_axis_word;

    typedef struct packed {
        logic        is_static;
        logic [31:0] mass;
    } t_mass_word;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } t_clamp;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_RD_WAIT,
        S_ST_G, S_ST_GL, S_ST_RD, S_ST_WR,
        S_ET_RD, S_ET_MUL, S_ET_WR,
        S_C_LD, S_C_LEN, S_C_AREA, S_C_PICK,
        S_C_MUL1, S_C_DIV1, S_C_MUL2, S_C_DIV2, S_C_VEL,
        S_C_DT, S_C_STA, S_C_STB, S_C_CHK, S_C_WB,
        S_FINISH
    } t_state;

    // Clamp a widened signed value into signed 32 bits, flagging the clamp.
    function automatic t_clamp clamp32(input logic signed [35:0] v);
        t_clamp r;
        if (v > 36'sd2147483647) begin
            r.sat = 1'b1;
            r.val = 32'sh7FFFFFFF;
        end else if (v < -36'sd2147483648) begin
            r.sat = 1'b1;
            r.val = 32'sh80000000;
        end else begin
            r.sat = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

    function automatic t_clamp add32(input logic signed [31:0] a,
                                     input logic signed [31:0] b);
        logic signed [35:0] s;
        s = 36'(a) + 36'(b);
        return clamp32(s);
    endfunction

    // Strict overlap of two intervals.
    function automatic logic overlap(input logic signed [31:0] a_lo,
                                     input logic signed [31:0] a_hi,
                                     input logic signed [31:0] b_lo,
                                     input logic signed [31:0] b_hi);
        return (a_hi > b_lo) && (a_lo < b_hi);
    endfunction

endpackage

@@ sv/aabb_if.sv @@
// ----------------------------------------------------------------------------
// AABB collision resolver channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface aabb_cmd_if import aabb_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface aabb_res_if import aabb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

@@ sv/aabb_body_mem.sv @@
// ----------------------------------------------------------------------------
// AABB body store
// Per-axis box and velocity memory plus per-body mass and static memory,
// each with one write port and one registered read port.
// ----------------------------------------------------------------------------
module aabb_body_mem import aabb_pkg::*; #(
    parameter int BODY_COUNT = 16
) (
    input  logic                               i_clk,
    input  logic                               i_word_we,
    input  logic [$clog2(BODY_COUNT)+1:0]      i_word_waddr,
    input  t_axis_word                         i_word_wdata,
    input  logic [$clog2(BODY_COUNT)+1:0]      i_word_raddr,
    output t_axis_word                         o_word_rdata,
    input  logic                               i_mass_we,
    input  logic [$clog2(BODY_COUNT)-1:0]      i_mass_waddr,
    input  t_mass_word                         i_mass_wdata,
    input  logic [$clog2(BODY_COUNT)-1:0]      i_mass_raddr,
    output t_mass_word                         o_mass_rdata
);
    localparam int WORD_DEPTH = BODY_COUNT * 4;

    // Word address is {body, axis}; axis code 3 is never used.
    t_axis_word r_word_mem [WORD_DEPTH];
    t_mass_word r_mass_mem [BODY_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_word_we) begin
            r_word_mem[i_word_waddr] <= i_word_wdata;
        end
        o_word_rdata <= r_word_mem[i_word_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_mass_we) begin
            r_mass_mem[i_mass_waddr] <= i_mass_wdata;
        end
        o_mass_rdata <= r_mass_mem[i_mass_raddr];
    end

endmodule

@@ sv/aabb_div.sv @@
// ----------------------------------------------------------------------------
// AABB restoring divider
// Unsigned 65-bit by 33-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aabb_div import aabb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVISOR_W-1:0]  o_quotient
);
    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_num;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_quo;
    logic [DIVISOR_W-1:0]  r_den;
    logic [DIVISOR_W:0]    trial;
    logic                  take;

    assign trial = {r_rem, r_num[DIVIDEND_W-1]};
    assign take  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient is known to fit in the divisor width, so its upper bits
    // simply fall off the shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIVIDEND_W-2:0], 1'b0};
            if (take) begin
                r_rem <= DIVISOR_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DIVISOR_W-1:0];
            end
            r_quo <= {r_quo[DIVISOR_W-2:0], take};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ sv/aabb_elastic_collision_resolver_unit.sv @@
// ----------------------------------------------------------------------------
// AABB elastic collision resolver
// Body table with box, velocity, mass and static flag per body; tick start,
// pairwise elastic collision with separation stepping, and tick end.
// ----------------------------------------------------------------------------
// The block takes one command at a time and returns exactly one result for
// each. Start and end ticks walk the single read port of the body store one
// entry at a time. A collide pair that misses ends after the overlap test;
// a hit is dominated by the two runs of the bit-serial divider that compute
// the exchanged velocities, and by the separation steps.
// The body store has no reset; entries read before they are written return
// whatever the memory holds. Moved marks live in flip-flops and are cleared
// by reset and by every start tick. Configuration is written through a plain
// write port and must only change while no command is in flight.
// ----------------------------------------------------------------------------
module aabb_elastic_collision_resolver_unit import aabb_pkg::*; #(
    parameter int BODY_COUNT           = 16,
    parameter int MAX_SEPARATION_STEPS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    aabb_cmd_if.sink             i_cmd,
    aabb_res_if.source           o_res
);
    localparam int IW = $clog2(BODY_COUNT);
    localparam int AW = IW + 2;
    localparam int CW = $clog2(MAX_SEPARATION_STEPS + 2);

    // Configuration registers.
    logic [15:0]        r_step_time;
    logic signed [31:0] r_gravity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= STEP_TIME_RST;
            r_gravity   <= GRAVITY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP_TIME: r_step_time <= i_cfg_data[15:0];
                CFG_GRAVITY:   r_gravity   <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Sequencer and latched command.
    t_state r_state, n_state;
    logic [2:0]         r_k;
    logic [2:0]         r_kind;
    logic [IW-1:0]      r_a, r_b, r_i;
    logic [1:0]         r_ax;
    logic               r_a_ok, r_pair_ok, r_same;
    t_in_item           r_item;

    // Working copy of the two bodies of a pair.
    logic signed [31:0] r_alo [3];
    logic signed [31:0] r_ahi [3];
    logic signed [31:0] r_av  [3];
    logic signed [31:0] r_blo [3];
    logic signed [31:0] r_bhi [3];
    logic signed [31:0] r_bv  [3];
    logic signed [31:0] r_da  [3];
    logic signed [31:0] r_db  [3];
    logic signed [32:0] r_len [3];
    logic [63:0]        r_sx, r_sy, r_sz;
    logic [31:0]        r_ma, r_mb;
    logic               r_sta, r_stb;
    logic [1:0]         r_w;
    logic               r_neg;
    logic [32:0]        r_q1, r_q2;
    logic [CW-1:0]      r_cnt;
    logic               r_bounce;

    logic signed [31:0] r_g;
    t_axis_word         r_tw;
    logic               r_tst;
    logic [BODY_COUNT-1:0] r_moved;

    // Result being assembled and the output register.
    logic signed [31:0] r_rd_lo, r_rd_hi, r_rd_vel;
    logic               r_collided, r_bounced, r_sat;
    logic               r_out_valid;
    t_out_item          r_out;
    logic               out_free;

    // Shared multiplier, registered product.
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] r_mul_p;
    logic signed [31:0]       scaled;

    // Memory ports.
    logic        word_we, mass_we;
    logic [AW-1:0] word_waddr, word_raddr;
    logic [IW-1:0] mass_waddr, mass_raddr;
    t_axis_word  word_wdata, rword;
    t_mass_word  mass_wdata, rmass;

    // Divider.
    logic        div_start, div_done;
    logic [DIVIDEND_W-1:0] div_num;
    logic [DIVISOR_W-1:0]  div_quo;

    logic               cmd_take;
    logic               last_body;
    logic signed [31:0] va, vb;
    logic signed [32:0] dv;
    logic [31:0]        dmag;
    logic [32:0]        mass_sum;
    logic [2:0]         ov;
    logic signed [32:0] len_c [3];
    logic signed [MUL_W-1:0] step_ext;
    t_clamp             st_a_lo [3], st_a_hi [3], st_b_lo [3], st_b_hi [3];
    t_clamp             g_sum, et_lo, et_hi, na_c, nb_c, nega_c, negb_c;
    logic               sat_a, sat_b;
    logic               ov_w;

    aabb_body_mem #(.BODY_COUNT(BODY_COUNT)) u_mem (
        .i_clk        (i_clk),
        .i_word_we    (word_we),
        .i_word_waddr (word_waddr),
        .i_word_wdata (word_wdata),
        .i_word_raddr (word_raddr),
        .o_word_rdata (rword),
        .i_mass_we    (mass_we),
        .i_mass_waddr (mass_waddr),
        .i_mass_wdata (mass_wdata),
        .i_mass_raddr (mass_raddr),
        .o_mass_rdata (rmass)
    );

    aabb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (mass_sum),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign cmd_take  = i_cmd.valid && i_cmd.ready;
    assign out_free  = !r_out_valid || o_res.ready;
    assign last_body = (r_i == IW'(BODY_COUNT - 1));
    assign step_ext  = MUL_W'($signed({1'b0, r_step_time}));

    // The product register holds v * step_time; an arithmetic drop of the
    // low sixteen bits gives the floor-rounded displacement.
    assign scaled = r_mul_p[47:16];

    // Velocities on the chosen axis and the magnitude of their difference.
    // The same magnitude serves both exchanges, only the sign flips.
    assign va       = r_av[r_w];
    assign vb       = r_bv[r_w];
    assign dv       = 33'(vb) - 33'(va);
    assign dmag     = dv[32] ? 32'(-dv) : dv[31:0];
    assign mass_sum = {1'b0, r_ma} + {1'b0, r_mb};
    assign div_num  = {r_mul_p[63:0], 1'b0};

    always_comb begin
        for (int x = 0; x < 3; x++) begin
            ov[x]    = overlap(r_alo[x], r_ahi[x], r_blo[x], r_bhi[x]);
            len_c[x] = 33'((r_ahi[x] < r_bhi[x]) ? r_ahi[x] : r_bhi[x])
                     - 33'((r_alo[x] > r_blo[x]) ? r_alo[x] : r_blo[x]);
            st_a_lo[x] = add32(r_alo[x], r_da[x]);
            st_a_hi[x] = add32(r_ahi[x], r_da[x]);
            // For a body paired with itself the second step lands on the
            // already stepped copy.
            st_b_lo[x] = add32(r_same ? r_alo[x] : r_blo[x], r_db[x]);
            st_b_hi[x] = add32(r_same ? r_ahi[x] : r_bhi[x], r_db[x]);
        end
    end

    assign sat_a = st_a_lo[0].sat | st_a_hi[0].sat | st_a_lo[1].sat | st_a_hi[1].sat
                 | st_a_lo[2].sat | st_a_hi[2].sat;
    assign sat_b = st_b_lo[0].sat | st_b_hi[0].sat | st_b_lo[1].sat | st_b_hi[1].sat
                 | st_b_lo[2].sat | st_b_hi[2].sat;
    assign ov_w  = overlap(r_alo[r_w], r_ahi[r_w], r_blo[r_w], r_bhi[r_w]);

    assign g_sum  = add32(rword.vel, r_g);
    assign et_lo  = add32(r_tw.lo, scaled);
    assign et_hi  = add32(r_tw.hi, scaled);
    assign na_c   = clamp32(36'(va) + (r_neg ? -36'($signed({3'b0, r_q1}))
                                             :  36'($signed({3'b0, r_q1}))));
    assign nb_c   = clamp32(36'(vb) + (r_neg ?  36'($signed({3'b0, r_q2}))
                                             : -36'($signed({3'b0, r_q2}))));
    assign nega_c = clamp32(-36'(va));
    assign negb_c = clamp32(-36'(vb));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (cmd_take) n_state = S_DISPATCH;
            S_DISPATCH: begin
                case (r_kind)
                    KIND_RD_AXIS: n_state = (r_a_ok && r_ax != AXIS_NONE) ? S_RD_WAIT
                                                                         : S_FINISH;
                    KIND_START:   n_state = S_ST_G;
                    KIND_COLLIDE: n_state = r_pair_ok ? S_C_LD : S_FINISH;
                    KIND_END:     n_state = S_ET_RD;
                    default:      n_state = S_FINISH;
                endcase
            end
            S_RD_WAIT:  n_state = S_FINISH;
            S_ST_G:     n_state = S_ST_GL;
            S_ST_GL:    n_state = S_ST_RD;
            S_ST_RD:    n_state = S_ST_WR;
            S_ST_WR:    n_state = last_body ? S_FINISH : S_ST_RD;
            S_ET_RD:    n_state = S_ET_MUL;
            S_ET_MUL:   n_state = S_ET_WR;
            S_ET_WR:    n_state = (last_body && r_ax == AXIS_Z) ? S_FINISH : S_ET_RD;
            S_C_LD:     if (r_k == 3'd6) n_state = S_C_LEN;
            S_C_LEN:    n_state = (&ov) ? S_C_AREA : S_FINISH;
            S_C_AREA:   if (r_k == 3'd3) n_state = S_C_PICK;
            S_C_PICK:   n_state = S_C_MUL1;
            S_C_MUL1:   n_state = (mass_sum == '0) ? S_C_VEL : S_C_DIV1;
            S_C_DIV1:   if (div_done) n_state = S_C_MUL2;
            S_C_MUL2:   n_state = S_C_DIV2;
            S_C_DIV2:   if (div_done) n_state = S_C_VEL;
            S_C_VEL:    n_state = S_C_DT;
            S_C_DT:     if (r_k == 3'd6) n_state = S_C_STA;
            S_C_STA:    n_state = S_C_STB;
            S_C_STB:    n_state = S_C_CHK;
            S_C_CHK: begin
                if (r_bounce) begin
                    n_state = S_C_WB;
                end else if (r_cnt > CW'(MAX_SEPARATION_STEPS)) begin
                    n_state = S_C_DT;
                end else if (ov_w) begin
                    n_state = S_C_STA;
                end else begin
                    n_state = S_C_WB;
                end
            end
            S_C_WB:     if (r_k == 3'd5) n_state = S_FINISH;
            S_FINISH:   if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Control outputs: memory ports, multiplier operands, divider start.
    always_comb begin
        i_cmd.ready = (r_state == S_IDLE);
        word_we     = 1'b0;
        word_waddr  = '0;
        word_wdata  = '0;
        word_raddr  = '0;
        mass_we     = 1'b0;
        mass_waddr  = r_a;
        mass_wdata  = {r_item.is_static, r_item.mass};
        mass_raddr  = r_i;
        mul_a       = '0;
        mul_b       = step_ext;
        div_start   = 1'b0;
        case (r_state)
            S_DISPATCH: begin
                word_waddr = {r_a, r_ax};
                word_raddr = {r_a, r_ax};
                word_wdata = {r_item.lo_coord, r_item.hi_coord, r_item.velocity};
                word_we    = (r_kind == KIND_WR_AXIS) && r_a_ok && (r_ax != AXIS_NONE);
                mass_we    = (r_kind == KIND_WR_MASS) && r_a_ok;
            end
            S_ST_G: begin
                mul_a = MUL_W'(r_gravity);
            end
            S_ST_RD: begin
                word_raddr = {r_i, AXIS_Y};
            end
            S_ST_WR: begin
                word_waddr = {r_i, AXIS_Y};
                word_wdata = {rword.lo, rword.hi, g_sum.val};
                word_we    = !rmass.is_static;
            end
            S_ET_RD: begin
                word_raddr = {r_i, r_ax};
            end
            S_ET_MUL: begin
                mul_a = MUL_W'(rword.vel);
            end
            S_ET_WR: begin
                word_waddr = {r_i, r_ax};
                if (r_tst) begin
                    word_wdata = {r_tw.lo, r_tw.hi, 32'sd0};
                    word_we    = 1'b1;
                end else begin
                    word_wdata = {et_lo.val, et_hi.val, r_tw.vel};
                    word_we    = !r_moved[r_i];
                end
            end
            S_C_LD: begin
                if (r_k < 3'd3) begin
                    word_raddr = {r_a, 2'(r_k)};
                end else begin
                    word_raddr = {r_b, 2'(r_k - 3'd3)};
                end
                mass_raddr = (r_k == 3'd0) ? r_a : r_b;
            end
            S_C_AREA: begin
                case (r_k)
                    3'd0: begin
                        mul_a = MUL_W'(r_len[1]);
                        mul_b = MUL_W'(r_len[2]);
                    end
                    3'd1: begin
                        mul_a = MUL_W'(r_len[0]);
                        mul_b = MUL_W'(r_len[2]);
                    end
                    default: begin
                        mul_a = MUL_W'(r_len[0]);
                        mul_b = MUL_W'(r_len[1]);
                    end
                endcase
            end
            S_C_MUL1: begin
                mul_a = MUL_W'($signed({2'b0, dmag}));
                mul_b = MUL_W'($signed({2'b0, r_mb}));
            end
            S_C_MUL2: begin
                mul_a = MUL_W'($signed({2'b0, dmag}));
                mul_b = MUL_W'($signed({2'b0, r_ma}));
            end
            S_C_DIV1, S_C_DIV2: begin
                div_start = (r_k == 3'd0);
            end
            S_C_DT: begin
                if (r_k < 3'd3) begin
                    mul_a = MUL_W'(r_av[2'(r_k)]);
                end else begin
                    mul_a = MUL_W'(r_bv[2'(r_k - 3'd3)]);
                end
            end
            S_C_WB: begin
                if (r_k < 3'd3) begin
                    word_waddr = {r_a, 2'(r_k)};
                    word_wdata = {r_alo[2'(r_k)], r_ahi[2'(r_k)], r_av[2'(r_k)]};
                end else begin
                    word_waddr = {r_b, 2'(r_k - 3'd3)};
                    word_wdata = {r_blo[2'(r_k - 3'd3)], r_bhi[2'(r_k - 3'd3)],
                                  r_bv[2'(r_k - 3'd3)]};
                end
                word_we = (r_k < 3'd6);
            end
            default: ;
        endcase
    end

    // State register and the step counter within a state; the counter
    // restarts on every state change and sticks at its top value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_k <= '0;
            end else if (r_k != 3'd7) begin
                r_k <= r_k + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul_p <= mul_a * mul_b;
    end

    // Moved marks: set by a hit, cleared by reset and by a start tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moved <= '0;
        end else if (r_state == S_ST_WR && last_body) begin
            r_moved <= '0;
        end else if (r_state == S_C_LEN && (&ov)) begin
            r_moved[r_a] <= 1'b1;
            r_moved[r_b] <= 1'b1;
        end
    end

    // Datapath. Every access to the body store is a read whose data is used
    // before that entry is written back, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (cmd_take) begin
                    r_item     <= i_cmd.item;
                    r_kind     <= i_cmd.item.kind;
                    r_a        <= IW'(i_cmd.item.body);
                    r_b        <= IW'(i_cmd.item.other_body);
                    r_ax       <= i_cmd.item.axis;
                    r_a_ok     <= (32'(i_cmd.item.body) < BODY_COUNT);
                    r_pair_ok  <= (32'(i_cmd.item.body) < BODY_COUNT)
                               && (32'(i_cmd.item.other_body) < BODY_COUNT);
                    r_same     <= (i_cmd.item.body == i_cmd.item.other_body);
                    r_i        <= '0;
                    r_w        <= AXIS_X;
                    r_cnt      <= '0;
                    r_bounce   <= 1'b0;
                    r_collided <= 1'b0;
                    r_bounced  <= 1'b0;
                    r_sat      <= 1'b0;
                    r_rd_lo    <= '0;
                    r_rd_hi    <= '0;
                    r_rd_vel   <= '0;
                end
            end
            S_DISPATCH: begin
                if (r_kind == KIND_END) begin
                    r_ax <= AXIS_X;
                end
            end
            S_RD_WAIT: begin
                r_rd_lo  <= rword.lo;
                r_rd_hi  <= rword.hi;
                r_rd_vel <= rword.vel;
            end
            S_ST_GL: begin
                r_g <= scaled;
            end
            S_ST_WR: begin
                if (!rmass.is_static) begin
                    r_sat <= r_sat | g_sum.sat;
                end
                r_i <= r_i + 1'b1;
            end
            S_ET_MUL: begin
                r_tw  <= rword;
                r_tst <= rmass.is_static;
            end
            S_ET_WR: begin
                if (!r_tst && !r_moved[r_i]) begin
                    r_sat <= r_sat | et_lo.sat | et_hi.sat;
                end
                if (r_ax == AXIS_Z) begin
                    r_ax <= AXIS_X;
                    r_i  <= r_i + 1'b1;
                end else begin
                    r_ax <= r_ax + 2'd1;
                end
            end
            S_C_LD: begin
                if (r_k >= 3'd1 && r_k <= 3'd3) begin
                    r_alo[2'(r_k - 3'd1)] <= rword.lo;
                    r_ahi[2'(r_k - 3'd1)] <= rword.hi;
                    r_av[2'(r_k - 3'd1)]  <= rword.vel;
                end else if (r_k >= 3'd4 && r_k <= 3'd6) begin
                    r_blo[2'(r_k - 3'd4)] <= rword.lo;
                    r_bhi[2'(r_k - 3'd4)] <= rword.hi;
                    r_bv[2'(r_k - 3'd4)]  <= rword.vel;
                end
                if (r_k == 3'd1) begin
                    r_ma  <= rmass.mass;
                    r_sta <= rmass.is_static;
                end
                if (r_k == 3'd2) begin
                    r_mb  <= rmass.mass;
                    r_stb <= rmass.is_static;
                end
            end
            S_C_LEN: begin
                for (int x = 0; x < 3; x++) begin
                    r_len[x] <= len_c[x];
                end
                r_collided <= &ov;
            end
            S_C_AREA: begin
                case (r_k)
                    3'd1:    r_sx <= r_mul_p[63:0];
                    3'd2:    r_sy <= r_mul_p[63:0];
                    3'd3:    r_sz <= r_mul_p[63:0];
                    default: ;
                endcase
            end
            S_C_PICK: begin
                // Ties go to the lower axis.
                if (r_sx >= r_sy && r_sx >= r_sz) begin
                    r_w <= AXIS_X;
                end else if (r_sy >= r_sz) begin
                    r_w <= AXIS_Y;
                end else begin
                    r_w <= AXIS_Z;
                end
            end
            S_C_MUL1: begin
                r_neg <= dv[32];
                if (mass_sum == '0) begin
                    // Both masses zero: the exchange is skipped and flagged.
                    r_sat <= 1'b1;
                    r_q1  <= '0;
                    r_q2  <= '0;
                end
            end
            S_C_DIV1: begin
                if (div_done) r_q1 <= div_quo;
            end
            S_C_DIV2: begin
                if (div_done) r_q2 <= div_quo;
            end
            S_C_VEL: begin
                r_av[r_w] <= na_c.val;
                r_bv[r_w] <= nb_c.val;
                r_sat     <= r_sat | na_c.sat | nb_c.sat;
            end
            S_C_DT: begin
                if (r_k >= 3'd1 && r_k <= 3'd3) begin
                    r_da[2'(r_k - 3'd1)] <= scaled;
                end else if (r_k >= 3'd4 && r_k <= 3'd6) begin
                    r_db[2'(r_k - 3'd4)] <= scaled;
                end
            end
            S_C_STA: begin
                if (!r_sta) begin
                    for (int x = 0; x < 3; x++) begin
                        r_alo[x] <= st_a_lo[x].val;
                        r_ahi[x] <= st_a_hi[x].val;
                    end
                    r_sat <= r_sat | sat_a;
                end
            end
            S_C_STB: begin
                if (!r_stb) begin
                    for (int x = 0; x < 3; x++) begin
                        r_blo[x] <= st_b_lo[x].val;
                        r_bhi[x] <= st_b_hi[x].val;
                        if (r_same) begin
                            r_alo[x] <= st_b_lo[x].val;
                            r_ahi[x] <= st_b_hi[x].val;
                        end
                    end
                    r_sat <= r_sat | sat_b;
                end
                if (!r_bounce) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_C_CHK: begin
                // Once the step count passes the limit, whether or not the pair still
                // overlaps: reverse both velocities and take one last step.
                if (!r_bounce && r_cnt > CW'(MAX_SEPARATION_STEPS)) begin
                    r_av[r_w] <= nega_c.val;
                    r_bv[r_w] <= negb_c.val;
                    r_sat     <= r_sat | nega_c.sat | negb_c.sat;
                    r_bounce  <= 1'b1;
                    r_bounced <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Output register: a finished result waits here until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && out_free) begin
            r_out.read_lo          <= r_rd_lo;
            r_out.read_hi          <= r_rd_hi;
            r_out.read_velocity    <= r_rd_vel;
            r_out.collided         <= r_collided;
            r_out.chosen_axis      <= r_w;
            r_out.bounced          <= r_bounced;
            r_out.separation_steps <= 4'(r_cnt);
            r_out.saturated        <= r_sat;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.item  = r_out;

    // The body store is written only by states that own a write.
    a_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        word_we |-> (r_state == S_DISPATCH || r_state == S_ST_WR
                  || r_state == S_ET_WR || r_state == S_C_WB))
        else $error("body store written outside a write state");

    // The bounce happens exactly one step past the limit.
    a_bounce_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bounce |-> (r_cnt == CW'(MAX_SEPARATION_STEPS + 1)))
        else $error("bounce taken at the wrong step count");

    // The step count never runs past the bounce point.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cnt <= CW'(MAX_SEPARATION_STEPS + 1)))
        else $error("separation step count overran");

    // A start tick leaves every moved mark clear.
    a_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ST_WR && last_body) |=> (r_moved == '0))
        else $error("moved marks not cleared by start tick");

    // A blocked result holds the sequencer in its final state.
    a_finish_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !out_free) |=> (r_state == S_FINISH))
        else $error("result dropped while output register busy");

endmodule
